// ----- hdl/pctd_pkg.sv -----
// types, constants and helper functions shared by the percent decoder
package pctd_pkg;

	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D9  = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] HEX_TEN = 8'd10;

	localparam int FIFO_DEPTH = 4;
	localparam int CMD_BYTES  = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	// one queued command: up to three bytes to emit, last flag on the final one
	typedef struct packed {
		logic [1:0]                     cnt;
		logic [CMD_BYTES-1:0][7:0]      bytes;
		logic                           last;
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic dec;
		logic up;
		logic lo;
		dec = (c >= CH_D0) && (c <= CH_D9);
		up  = (c >= CH_UA) && (c <= CH_UF);
		lo  = (c >= CH_LA) && (c <= CH_LF);
		return dec || up || lo;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if ((c >= CH_UA) && (c <= CH_UF)) begin
			v = c - CH_UA + HEX_TEN;
		end else if ((c >= CH_LA) && (c <= CH_LF)) begin
			v = c - CH_LA + HEX_TEN;
		end else if ((c >= CH_D0) && (c <= CH_D9)) begin
			v = c - CH_D0;
		end else begin
			v = 8'd0;
		end
		return v[3:0];
	endfunction

endpackage

// ----- hdl/pctd_front.sv -----
// front end: escape tracking and classification of each input word into a command
module pctd_front
	import pctd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     enc_valid,
	input  logic     q_full,
	input  in_word_t enc_word,
	output logic     enc_stall,
	output logic     push,
	output cmd_t     push_cmd
);

	phase_t     phase_q;
	phase_t     nxt_phase;
	logic [7:0] digit_q;
	logic       take;
	logic       pct_open;
	logic       hx;
	logic [7:0] b;
	logic       lst;
	cmd_t       cmd;

	assign enc_stall = q_full;
	assign take      = enc_valid && !q_full;
	assign b         = enc_word.in_byte;
	assign lst       = enc_word.in_last;
	assign hx        = is_hex(b);
	// a '%' that is not the last byte opens an escape
	assign pct_open  = (b == CH_PCT) && !lst;

	always_comb begin
		nxt_phase = phase_q;
		cmd       = '0;
		cmd.last  = lst;
		unique case (phase_q)
			PH_PCT: begin
				if (hx && !lst) begin
					nxt_phase = PH_DIGIT;
				end else if (pct_open) begin
					nxt_phase    = PH_PCT;
					cmd.cnt      = 2'd1;
					cmd.bytes[0] = CH_PCT;
					cmd.last     = 1'b0;
				end else begin
					nxt_phase    = PH_IDLE;
					cmd.cnt      = 2'd2;
					cmd.bytes[0] = CH_PCT;
					cmd.bytes[1] = b;
				end
			end
			PH_DIGIT: begin
				if (hx) begin
					nxt_phase    = PH_IDLE;
					cmd.cnt      = 2'd1;
					cmd.bytes[0] = {hex_val(digit_q), hex_val(b)};
				end else if (pct_open) begin
					nxt_phase    = PH_PCT;
					cmd.cnt      = 2'd2;
					cmd.bytes[0] = CH_PCT;
					cmd.bytes[1] = digit_q;
					cmd.last     = 1'b0;
				end else begin
					nxt_phase    = PH_IDLE;
					cmd.cnt      = 2'd3;
					cmd.bytes[0] = CH_PCT;
					cmd.bytes[1] = digit_q;
					cmd.bytes[2] = b;
				end
			end
			default: begin
				if (pct_open) begin
					nxt_phase = PH_PCT;
				end else begin
					nxt_phase    = PH_IDLE;
					cmd.cnt      = 2'd1;
					cmd.bytes[0] = b;
				end
			end
		endcase
	end

	assign push     = take && (cmd.cnt != 2'd0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (take) begin
			phase_q <= nxt_phase;
		end
	end

	// held first digit, only read in the digit phase
	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_PCT) && hx && !lst) begin
			digit_q <= b;
		end
	end

endmodule

// ----- hdl/pctd_fifo.sv -----
// short command queue between front and back end
module pctd_fifo
	import pctd_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hdl/pctd_back.sv -----
// back end: serializes queued commands into output words through an output register
module pctd_back
	import pctd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      head,
	input  logic      dec_stall,
	output logic      pop,
	output logic      dec_valid,
	output out_word_t dec_word
);

	logic       dv_q;
	out_word_t  word_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic       fin;
	logic [7:0] sel;

	assign load = !dv_q || !dec_stall;
	assign take = load && !empty;
	assign fin  = (idx_q == (head.cnt - 2'd1));
	assign pop  = take && fin;

	always_comb begin
		unique case (idx_q)
			2'd1:    sel = head.bytes[1];
			2'd2:    sel = head.bytes[2];
			default: sel = head.bytes[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				dv_q <= !empty;
			end
			if (take) begin
				idx_q <= fin ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_q.out_byte <= sel;
			word_q.out_last <= head.last && fin;
		end
	end

	assign dec_valid = dv_q;
	assign dec_word  = word_q;

endmodule

// ----- hdl/percent_decoder.sv -----
// top level of the streaming url percent decoder
//
// Encoded bytes arrive on the enc channel (enc_valid, enc_stall, enc_word), one
// word per string byte with in_last on the final byte. Decoded bytes leave on
// the dec channel (dec_valid, dec_stall, dec_word) with out_last on the final
// decoded byte. A word moves when valid is high and stall is low.
// The front end tracks the escape phase and turns every input word into a
// command of zero to three output bytes; commands wait in a small queue
// (QDEPTH entries) and the back end emits one byte per cycle from them while dec_stall is low.
// An accepted input word reaches the output through the queue and then the output register.
// Input is taken at one word per cycle while the queue has room; output runs
// at one word per cycle while dec_stall is low, so a stream of inputs that
// expand to two or three bytes fills the queue and is then held by enc_stall.
// When the receiver stalls, the output register holds its word, the queue
// fills and enc_stall rises once it is full.
// Reset returns the escape phase to idle and empties the queue and output.
module percent_decoder
	import pctd_pkg::*;
#(
	parameter int QDEPTH = FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      enc_valid,
	output logic      enc_stall,
	input  in_word_t  enc_word,
	output logic      dec_valid,
	input  logic      dec_stall,
	output out_word_t dec_word
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	logic full;
	logic empty;
	cmd_t head;

	pctd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (enc_valid),
		.q_full    (full),
		.enc_word  (enc_word),
		.enc_stall (enc_stall),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	pctd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	pctd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.dec_stall (dec_stall),
		.pop       (pop),
		.dec_valid (dec_valid),
		.dec_word  (dec_word)
	);

endmodule
